// ===== hdl/eab_pkg.sv =====
// Package: constants, types and helpers for the Euler-angle basis block.
package eab_pkg;

  localparam int ANGLE_BITS        = 16;
  localparam int FRAC_BITS         = 14;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int WORK_BITS = 30;
  localparam int TABLE_LEN = 24;
  localparam int VAL_W     = 34;   // Q30 value plus headroom
  localparam int Z_W       = 34;   // residual phase plus headroom
  localparam logic signed [VAL_W-1:0] GAIN_Q30 = 34'sd652032874;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [Z_W-1:0]   ph_t;

  // input transfer: yaw, pitch, roll binary angles
  typedef struct packed {
    logic [ANGLE_BITS-1:0] yaw_angle;
    logic [ANGLE_BITS-1:0] pitch_angle;
    logic [ANGLE_BITS-1:0] roll_angle;
  } eab_angles_t;

  // output transfer: forward, right, up vectors in Q2.FRAC_BITS
  typedef struct packed {
    logic signed [FRAC_BITS+1:0] forward_x;
    logic signed [FRAC_BITS+1:0] forward_y;
    logic signed [FRAC_BITS+1:0] forward_z;
    logic signed [FRAC_BITS+1:0] right_x;
    logic signed [FRAC_BITS+1:0] right_y;
    logic signed [FRAC_BITS+1:0] right_z;
    logic signed [FRAC_BITS+1:0] up_x;
    logic signed [FRAC_BITS+1:0] up_y;
    logic signed [FRAC_BITS+1:0] up_z;
  } eab_basis_t;

  typedef struct packed {
    val_t s;
    val_t c;
  } sc_t;

  typedef struct packed {
    sc_t y;
    sc_t p;
    sc_t r;
  } trig_t;

  function automatic ph_t atan_turns(input int i);
    ph_t t;
    unique case (i)
      0:  t = 34'sd536870912;
      1:  t = 34'sd316933406;
      2:  t = 34'sd167458907;
      3:  t = 34'sd85004756;
      4:  t = 34'sd42667331;
      5:  t = 34'sd21354465;
      6:  t = 34'sd10679838;
      7:  t = 34'sd5340245;
      8:  t = 34'sd2670163;
      9:  t = 34'sd1335087;
      10: t = 34'sd667544;
      11: t = 34'sd333772;
      12: t = 34'sd166886;
      13: t = 34'sd83443;
      14: t = 34'sd41722;
      15: t = 34'sd20861;
      16: t = 34'sd10430;
      17: t = 34'sd5215;
      18: t = 34'sd2608;
      19: t = 34'sd1304;
      20: t = 34'sd652;
      21: t = 34'sd326;
      22: t = 34'sd163;
      23: t = 34'sd81;
      default: t = '0;
    endcase
    return t;
  endfunction

  // Q30 x Q30 -> Q30, round half up
  function automatic val_t qmul(input val_t a, input val_t b);
    logic signed [2*VAL_W-1:0] p;
    p = a * b + (68'sd1 <<< (WORK_BITS - 1));
    return val_t'(p >>> WORK_BITS);
  endfunction

endpackage

// ===== hdl/eab_if.sv =====
// Valid/ready channel interface.
interface eab_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/euler_angles_to_basis_vectors.sv =====
// Euler angles (yaw, pitch, roll) to forward/right/up basis vectors.
// Fully pipelined: one item accepted per clock while the output is not stalled.
// Registered steps in order: quadrant split, the CORDIC stages, quadrant fold, two product
// stages, rounding. The whole pipeline advances whenever the output register
// is empty or being taken, so a stalled sink holds every stage in place.
module euler_angles_to_basis_vectors import eab_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input logic clk,
  input logic rst,
  eab_if.sink   in_ch,
  eab_if.source out_ch
);
  logic                        en, cv, mv;
  trig_t                       trig;
  logic signed [FRAC_BITS+1:0] comp [9];
  logic [ANGLE_BITS-1:0]       ang [3];

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  assign ang[0] = in_ch.data.yaw_angle;
  assign ang[1] = in_ch.data.pitch_angle;
  assign ang[2] = in_ch.data.roll_angle;

  eab_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk, .rst, .en, .in_valid(in_ch.valid), .ang, .out_valid(cv), .trig);

  eab_matrix u_matrix (
    .clk, .rst, .en, .in_valid(cv), .trig, .out_valid(mv), .comp);

  assign out_ch.valid          = mv;
  assign out_ch.data.forward_x = comp[0];
  assign out_ch.data.forward_y = comp[1];
  assign out_ch.data.forward_z = comp[2];
  assign out_ch.data.right_x   = comp[3];
  assign out_ch.data.right_y   = comp[4];
  assign out_ch.data.right_z   = comp[5];
  assign out_ch.data.up_x      = comp[6];
  assign out_ch.data.up_y      = comp[7];
  assign out_ch.data.up_z      = comp[8];
endmodule

// ===== hdl/eab_cordic.sv =====
// Pipelined rotation-mode CORDIC: sine and cosine of three angles.
module eab_cordic import eab_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [ANGLE_BITS-1:0] ang [3],
  output logic                  out_valid,
  output trig_t                 trig
);
  localparam int N = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

  val_t       x [N+1][3];
  val_t       y [N+1][3];
  ph_t        z [N+1][3];
  logic [1:0] q [N+1][3];
  logic       v [N+1];

  // quadrant split and residual
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic [31:0] phase, r;
        logic [1:0]  qq;
        phase = {ang[k], {(32-ANGLE_BITS){1'b0}}};
        qq = 2'((phase + 32'h2000_0000) >> 30);
        r = phase - {qq, 30'd0};
        q[0][k] <= qq;
        z[0][k] <= ph_t'($signed(r));
        x[0][k] <= GAIN_Q30;
        y[0][k] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          q[i+1][k] <= q[i][k];
          if (!z[i][k][Z_W-1]) begin
            x[i+1][k] <= x[i][k] - (y[i][k] >>> i);
            y[i+1][k] <= y[i][k] + (x[i][k] >>> i);
            z[i+1][k] <= z[i][k] - atan_turns(i);
          end else begin
            x[i+1][k] <= x[i][k] + (y[i][k] >>> i);
            y[i+1][k] <= y[i][k] - (x[i][k] >>> i);
            z[i+1][k] <= z[i][k] + atan_turns(i);
          end
        end
      end
    end
  end

  sc_t sc [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unique case (q[N][k])
        2'd0:    begin sc[k].c = x[N][k];  sc[k].s = y[N][k];  end
        2'd1:    begin sc[k].c = -y[N][k]; sc[k].s = x[N][k];  end
        2'd2:    begin sc[k].c = -x[N][k]; sc[k].s = -y[N][k]; end
        default: begin sc[k].c = y[N][k];  sc[k].s = -x[N][k]; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[N];
    end
    if (en) begin
      trig <= '{y: sc[0], p: sc[1], r: sc[2]};
    end
  end
endmodule

// ===== hdl/eab_matrix.sv =====
// Product pipeline: basis-vector components from sines and cosines.
module eab_matrix import eab_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  trig_t                      trig,
  output logic                       out_valid,
  output logic signed [FRAC_BITS+1:0] comp [9]
);
  localparam int SH = WORK_BITS - FRAC_BITS;
  localparam logic signed [VAL_W-1:0] LIM = VAL_W'(1) <<< FRAC_BITS;

  function automatic logic signed [FRAC_BITS+1:0] to_out(input val_t v);
    val_t r;
    r = (v + (VAL_W'(1) <<< (SH - 1))) >>> SH;
    if (r > LIM) r = LIM;
    if (r < -LIM) r = -LIM;
    return r[FRAC_BITS+1:0];
  endfunction

  // stage 1: first products
  trig_t t1;
  val_t  srsp, crsp, cpcy, cpsy, crsy, crcy, srcp, srsy, srcy, crcp;
  logic  v1, v2;
  val_t  a [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; out_valid <= v2;
    end
    if (en) begin
      t1   <= trig;
      srsp <= qmul(trig.r.s, trig.p.s);
      crsp <= qmul(trig.r.c, trig.p.s);
      cpcy <= qmul(trig.p.c, trig.y.c);
      cpsy <= qmul(trig.p.c, trig.y.s);
      crsy <= qmul(trig.r.c, trig.y.s);
      crcy <= qmul(trig.r.c, trig.y.c);
      srcp <= qmul(trig.r.s, trig.p.c);
      srsy <= qmul(trig.r.s, trig.y.s);
      srcy <= qmul(trig.r.s, trig.y.c);
      crcp <= qmul(trig.r.c, trig.p.c);
      // stage 2: second products
      a[0] <= cpcy;
      a[1] <= cpsy;
      a[2] <= -t1.p.s;
      a[3] <= crsy - qmul(srsp, t1.y.c);
      a[4] <= -qmul(srsp, t1.y.s) - crcy;
      a[5] <= -srcp;
      a[6] <= qmul(crsp, t1.y.c) + srsy;
      a[7] <= qmul(crsp, t1.y.s) - srcy;
      a[8] <= crcp;
      // stage 3: round and saturate
      for (int k = 0; k < 9; k++) comp[k] <= to_out(a[k]);
    end
  end
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for euler_angles_to_basis_vectors: directed rows, random angles.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import eab_pkg::*;

  // [8] forward_x ... [0] up_z
  typedef logic [8:0][15:0] basis_t;

  typedef struct {
    eab_angles_t ang;
    logic        fixed;
    basis_t      vec;
  } row_t;

  localparam int N_RANDOM   = 1000;
  localparam int LATENCY    = CORDIC_STAGES_DEF + 5;
  localparam int LIMIT      = 600000;
  localparam int STALL_AT   = 300;
  localparam int STALL_LEN  = 400;
  localparam int STAGES     = 16;

  localparam longint ATAN_TURNS [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  localparam string FIELD_NAMES [9] = '{"up_z", "up_y", "up_x", "right_z", "right_y",
    "right_x", "forward_z", "forward_y", "forward_x"};

  logic clk;
  logic rst;

  eab_if #(.payload_t(eab_angles_t)) in_ch  ();
  eab_if #(.payload_t(eab_basis_t))  out_ch ();

  euler_angles_to_basis_vectors u_top (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  basis_t expected_basis [$];
  int     n_sent;
  int     n_checked;
  int     n_errors;
  int     cycles;
  logic   sending_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Q30 product, round half up
  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b + (longint'(1) <<< 29)) >>> 30;
  endfunction

  function automatic logic [15:0] to_q14(input longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return 16'(r);
  endfunction

  task automatic sin_cos(input logic [15:0] a, output longint s, output longint c);
    logic [31:0] ph;
    logic [31:0] res;
    logic [1:0]  quad;
    longint      z, x, y, dx, dy;
    ph   = {a, 16'h0000};
    quad = 2'((ph + 32'h2000_0000) >> 30);
    res  = ph - {quad, 30'b0};
    z    = longint'($signed(res));
    x    = 652032874;
    y    = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TURNS[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TURNS[i];
      end
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic predict_basis(input eab_angles_t a, output basis_t v);
    longint sy, cy, sp, cp, sr, cr, srsp, crsp;
    sin_cos(a.yaw_angle, sy, cy);
    sin_cos(a.pitch_angle, sp, cp);
    sin_cos(a.roll_angle, sr, cr);
    srsp = q30_mul(sr, sp);
    crsp = q30_mul(cr, sp);
    v[8] = to_q14(q30_mul(cp, cy));
    v[7] = to_q14(q30_mul(cp, sy));
    v[6] = to_q14(-sp);
    v[5] = to_q14(-q30_mul(srsp, cy) + q30_mul(cr, sy));
    v[4] = to_q14(-q30_mul(srsp, sy) - q30_mul(cr, cy));
    v[3] = to_q14(-q30_mul(sr, cp));
    v[2] = to_q14(q30_mul(crsp, cy) + q30_mul(sr, sy));
    v[1] = to_q14(q30_mul(crsp, sy) - q30_mul(sr, cy));
    v[0] = to_q14(q30_mul(cr, cp));
  endtask

  function automatic eab_angles_t random_angles();
    eab_angles_t a;
    a = eab_angles_t'(48'({$urandom, $urandom}));
    // now and then pick quadrant and octant edges
    if ($urandom_range(0, 7) == 0)
      a.yaw_angle = 16'($urandom_range(0, 7) * 16'h2000 - $urandom_range(0, 1));
    if ($urandom_range(0, 7) == 0)
      a.pitch_angle = 16'($urandom_range(0, 7) * 16'h2000 - $urandom_range(0, 1));
    if ($urandom_range(0, 7) == 0)
      a.roll_angle = 16'($urandom_range(0, 7) * 16'h2000 - $urandom_range(0, 1));
    return a;
  endfunction

  task automatic send_angles(input eab_angles_t a, input basis_t v, input bit quiet);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= a;
    do @(posedge clk); while (!in_ch.ready);
    expected_basis.push_back(v);
    n_sent++;
  endtask

  // sender
  initial begin
    row_t        rows [$];
    basis_t      v;
    eab_angles_t a;
    bit          quiet;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    sending_done = 1'b0;
    n_sent       = 0;
    rst          = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    rows.push_back('{'{16'h0000, 16'h0000, 16'h0000}, 1'b1,
      {16'd16384, 16'd0, 16'd0, 16'd0, -16'sd16384, 16'd0, 16'd0, 16'd0, 16'd16384}});
    rows.push_back('{'{16'h4000, 16'h0000, 16'h0000}, 1'b1,
      {16'd0, 16'd16384, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, 16'd16384}});
    rows.push_back('{'{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0});
    rows.push_back('{'{16'h8000, 16'h8000, 16'h8000}, 1'b0, '0});
    rows.push_back('{'{16'hC000, 16'h4000, 16'h0000}, 1'b0, '0});
    rows.push_back('{'{16'h0000, 16'hC000, 16'h4000}, 1'b0, '0});
    rows.push_back('{'{16'h2000, 16'h1FFF, 16'hE000}, 1'b0, '0});
    rows.push_back('{'{16'h6000, 16'hA000, 16'h5FFF}, 1'b0, '0});
    rows.push_back('{'{16'h0001, 16'h7FFF, 16'h8001}, 1'b0, '0});
    rows.push_back('{'{16'h3FFF, 16'h4001, 16'hBFFF}, 1'b0, '0});
    rows.push_back('{'{16'hAAAA, 16'h5555, 16'h1234}, 1'b0, '0});
    rows.push_back('{'{16'h1000, 16'h0800, 16'hF800}, 1'b0, '0});

    foreach (rows[i]) begin
      if (rows[i].fixed) v = rows[i].vec;
      else predict_basis(rows[i].ang, v);
      send_angles(rows[i].ang, v, 1'b0);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      a = random_angles();
      predict_basis(a, v);
      quiet = ((i / 100) % 3) == 1;  // back-to-back stretches
      send_angles(a, v, quiet);
    end
    in_ch.valid  <= 1'b0;
    sending_done <= 1'b1;
  end

  // receiver: random stalls, one long hold-off to back up the pipeline
  initial begin
    int  hold;
    bit  stalled;
    out_ch.ready = 1'b0;
    stalled = 1'b0;
    @(negedge rst);
    forever begin
      hold = (((n_checked / 100) % 3) == 2) ? 0 : $urandom_range(0, 11);
      if (!stalled && n_checked >= STALL_AT) begin
        hold    = STALL_LEN;
        stalled = 1'b1;
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // result checker and watchdog
  initial begin
    basis_t want;
    basis_t got;
    n_checked = 0;
    n_errors  = 0;
    cycles    = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("euler_angles_to_basis_vectors verification failed");
        $finish;
      end
      if (!rst && out_ch.valid && out_ch.ready) begin
        got = basis_t'(out_ch.data);
        if (expected_basis.size() == 0) begin
          $error("unexpected result transfer %h", got);
          n_errors++;
        end else begin
          want = expected_basis.pop_front();
          for (int k = 0; k < 9; k++)
            if (got[k] !== want[k]) begin
              $error("%s: expected %0d, got %0d", FIELD_NAMES[k],
                     $signed(want[k]), $signed(got[k]));
              n_errors++;
            end
          n_checked++;
        end
      end
    end
  end

  // end of run
  initial begin
    @(negedge rst);
    wait (sending_done && expected_basis.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    $display("Sent %0d angle triples, checked %0d basis results", n_sent, n_checked);
    $display("Covered quadrant/octant edges, back-to-back runs and a %0d-cycle output stall",
             STALL_LEN);
    if (n_errors == 0 && expected_basis.size() == 0) begin
      $display("euler_angles_to_basis_vectors verification clean");
    end else begin
      $display("euler_angles_to_basis_vectors verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/eab_pkg.sv
hdl/eab_if.sv
hdl/eab_cordic.sv
hdl/eab_matrix.sv
hdl/euler_angles_to_basis_vectors.sv
tb/sv/testbench.sv
